[rtl/hri_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hri_pkg
// Shared types, widths and constant tables for the Halton radical inverse
// block: prime bases, their fixed-point reciprocals and the command and
// status types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hri_pkg;

  // Field and datapath widths.
  localparam int IDX_W     = 32;  // sample index
  localparam int DIM_W     = 5;   // dimension number
  localparam int FRAC_W    = 32;  // output fraction
  localparam int N_W       = IDX_W + 1;  // sequence index, never wraps
  localparam int BASE_W    = 9;   // largest prime is 311
  localparam int RECIP_W   = 32;
  localparam int ACC_W     = 64;
  localparam int MUL_A_W   = N_W - 16;  // upper slice of the index
  localparam int QUO_W     = 32;
  localparam int DEN_W     = 42;  // b^k stays below 2^41
  localparam int REM_W     = BASE_W + 1;  // remainder before correction is below 2*b
  localparam int SEL_W     = 6;
  localparam int PRIME_COUNT = 64;
  localparam int DIV_CNT_W = $clog2(FRAC_W);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_W - 1);
  localparam logic [63:0] TWO_POW32 = 64'd1 << 32;

  // The first 64 primes.
  localparam logic [BASE_W-1:0] PRIME_TABLE [PRIME_COUNT] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

  // Reciprocals floor(2^32 / p), folded at elaboration.
  localparam logic [RECIP_W-1:0] RECIP_TABLE [PRIME_COUNT] = '{
    32'(TWO_POW32 / PRIME_TABLE[0]),  32'(TWO_POW32 / PRIME_TABLE[1]),
    32'(TWO_POW32 / PRIME_TABLE[2]),  32'(TWO_POW32 / PRIME_TABLE[3]),
    32'(TWO_POW32 / PRIME_TABLE[4]),  32'(TWO_POW32 / PRIME_TABLE[5]),
    32'(TWO_POW32 / PRIME_TABLE[6]),  32'(TWO_POW32 / PRIME_TABLE[7]),
    32'(TWO_POW32 / PRIME_TABLE[8]),  32'(TWO_POW32 / PRIME_TABLE[9]),
    32'(TWO_POW32 / PRIME_TABLE[10]), 32'(TWO_POW32 / PRIME_TABLE[11]),
    32'(TWO_POW32 / PRIME_TABLE[12]), 32'(TWO_POW32 / PRIME_TABLE[13]),
    32'(TWO_POW32 / PRIME_TABLE[14]), 32'(TWO_POW32 / PRIME_TABLE[15]),
    32'(TWO_POW32 / PRIME_TABLE[16]), 32'(TWO_POW32 / PRIME_TABLE[17]),
    32'(TWO_POW32 / PRIME_TABLE[18]), 32'(TWO_POW32 / PRIME_TABLE[19]),
    32'(TWO_POW32 / PRIME_TABLE[20]), 32'(TWO_POW32 / PRIME_TABLE[21]),
    32'(TWO_POW32 / PRIME_TABLE[22]), 32'(TWO_POW32 / PRIME_TABLE[23]),
    32'(TWO_POW32 / PRIME_TABLE[24]), 32'(TWO_POW32 / PRIME_TABLE[25]),
    32'(TWO_POW32 / PRIME_TABLE[26]), 32'(TWO_POW32 / PRIME_TABLE[27]),
    32'(TWO_POW32 / PRIME_TABLE[28]), 32'(TWO_POW32 / PRIME_TABLE[29]),
    32'(TWO_POW32 / PRIME_TABLE[30]), 32'(TWO_POW32 / PRIME_TABLE[31]),
    32'(TWO_POW32 / PRIME_TABLE[32]), 32'(TWO_POW32 / PRIME_TABLE[33]),
    32'(TWO_POW32 / PRIME_TABLE[34]), 32'(TWO_POW32 / PRIME_TABLE[35]),
    32'(TWO_POW32 / PRIME_TABLE[36]), 32'(TWO_POW32 / PRIME_TABLE[37]),
    32'(TWO_POW32 / PRIME_TABLE[38]), 32'(TWO_POW32 / PRIME_TABLE[39]),
    32'(TWO_POW32 / PRIME_TABLE[40]), 32'(TWO_POW32 / PRIME_TABLE[41]),
    32'(TWO_POW32 / PRIME_TABLE[42]), 32'(TWO_POW32 / PRIME_TABLE[43]),
    32'(TWO_POW32 / PRIME_TABLE[44]), 32'(TWO_POW32 / PRIME_TABLE[45]),
    32'(TWO_POW32 / PRIME_TABLE[46]), 32'(TWO_POW32 / PRIME_TABLE[47]),
    32'(TWO_POW32 / PRIME_TABLE[48]), 32'(TWO_POW32 / PRIME_TABLE[49]),
    32'(TWO_POW32 / PRIME_TABLE[50]), 32'(TWO_POW32 / PRIME_TABLE[51]),
    32'(TWO_POW32 / PRIME_TABLE[52]), 32'(TWO_POW32 / PRIME_TABLE[53]),
    32'(TWO_POW32 / PRIME_TABLE[54]), 32'(TWO_POW32 / PRIME_TABLE[55]),
    32'(TWO_POW32 / PRIME_TABLE[56]), 32'(TWO_POW32 / PRIME_TABLE[57]),
    32'(TWO_POW32 / PRIME_TABLE[58]), 32'(TWO_POW32 / PRIME_TABLE[59]),
    32'(TWO_POW32 / PRIME_TABLE[60]), 32'(TWO_POW32 / PRIME_TABLE[61]),
    32'(TWO_POW32 / PRIME_TABLE[62]), 32'(TWO_POW32 / PRIME_TABLE[63])
  };

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_SETUP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_QB,
    OP_FIX,
    OP_DIV,
    OP_SAVE_X,
    OP_LOAD_OUT
  } op_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_QB,
    S_FIX,
    S_DIV,
    S_SAVE,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic axis;  // 0 selects the first base, 1 the second
  } cmd_t;

  typedef struct packed {
    logic last_digit;  // the quotient after this digit step is zero
  } status_t;

endpackage
`default_nettype wire

[rtl/hri_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hri_ctrl
// Controller state machine: sequences the digit loop, the long division and
// the output register for both axes, and runs the item handshakes.
// ----------------------------------------------------------------------------
module hri_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output hri_pkg::cmd_t         cmd,
  input  wire hri_pkg::status_t status
);
  import hri_pkg::*;

  state_t                state;
  state_t                state_next;
  logic                  axis;
  logic                  axis_next;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [DIV_CNT_W-1:0]  div_cnt_next;
  logic                  out_valid_next;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    axis_next      = axis;
    div_cnt_next   = div_cnt;
    cmd.op         = OP_NONE;
    cmd.axis       = axis;
    in_stall       = 1'b1;
    out_valid_next = out_valid & out_stall;

    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_START;
          axis_next  = 1'b0;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.op     = OP_SETUP;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_MUL_QB;
      end
      S_MUL_QB: begin
        cmd.op     = OP_MUL_QB;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.op = OP_FIX;
        if (status.last_digit) begin
          div_cnt_next = '0;
          state_next   = S_DIV;
        end else begin
          state_next = S_MUL_LO;
        end
      end
      S_DIV: begin
        cmd.op       = OP_DIV;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_SAVE;
        end
      end
      S_SAVE: begin
        if (!axis) begin
          cmd.op     = OP_SAVE_X;
          axis_next  = 1'b1;
          state_next = S_SETUP;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // The result register frees up when its item is taken.
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_LOAD_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/hri_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hri_datapath
// Digit extractor (reciprocal multiply with one correction), reversed-digit
// numerator and denominator registers, a one-bit-per-cycle restoring divider
// and the result registers.
// ----------------------------------------------------------------------------
module hri_datapath (
  input  wire logic                          clk,
  input  wire hri_pkg::cmd_t                 cmd,
  output hri_pkg::status_t                   status,
  input  wire logic [hri_pkg::IDX_W-1:0]     sample_index,
  input  wire logic [hri_pkg::DIM_W-1:0]     dimension,
  output logic      [hri_pkg::FRAC_W-1:0]    x_fraction,
  output logic      [hri_pkg::FRAC_W-1:0]    y_fraction
);
  import hri_pkg::*;

  logic [N_W-1:0]      n0;        // sequence index of the current item
  logic [DIM_W-1:0]    dim;
  logic [N_W-1:0]      n;         // index still to be taken apart
  logic [BASE_W-1:0]   base;
  logic [RECIP_W-1:0]  recip;
  logic [ACC_W-1:0]    acc;
  logic [N_W-1:0]      qb;
  logic [DEN_W-1:0]    numb;
  logic [DEN_W-1:0]    denb;
  logic [DEN_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [QUO_W-1:0]    quo;
  logic [FRAC_W-1:0]   x_hold;

  logic [SEL_W-1:0]            sel;
  logic [MUL_A_W-1:0]          mul_a;
  logic [MUL_A_W+RECIP_W-1:0]  prod;
  logic [QUO_W-1:0]            q_est;
  logic [QUO_W+BASE_W-1:0]     qb_full;
  logic [DEN_W+BASE_W-1:0]     numb_full;
  logic [DEN_W+BASE_W-1:0]     denb_full;
  logic [N_W-1:0]              r_full;
  logic [REM_W-1:0]            r;
  logic                        r_ge;
  logic [REM_W-1:0]            digit;
  logic [QUO_W-1:0]            q_fix;
  logic [DEN_W:0]              shifted;
  logic                        div_ge;

  // Base pair sits at consecutive table entries for each dimension.
  assign sel = {dim, cmd.axis};

  // Shared multiplier for the two halves of index times reciprocal.
  assign mul_a = (cmd.op == OP_MUL_HI) ? n[N_W-1:16] : {{(MUL_A_W-16){1'b0}}, n[15:0]};
  assign prod  = mul_a * recip;

  // Quotient estimate is low by at most one.
  assign q_est     = acc[ACC_W-1:ACC_W-QUO_W];
  assign qb_full   = q_est * base;
  assign numb_full = num * base;
  assign denb_full = den * base;

  // Remainder with a single correction step.
  assign r_full = n - qb;
  assign r      = r_full[REM_W-1:0];
  assign r_ge   = (r >= {1'b0, base});
  assign digit  = r_ge ? (r - {1'b0, base}) : r;
  assign q_fix  = q_est + QUO_W'(r_ge);

  assign status.last_digit = (q_fix == '0);

  // Restoring division step.
  assign shifted = {num, 1'b0};
  assign div_ge  = (shifted >= {1'b0, den});

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        n0  <= {1'b0, sample_index} + N_W'(1);
        dim <= dimension;
      end
      OP_SETUP: begin
        n     <= n0;
        base  <= PRIME_TABLE[sel];
        recip <= RECIP_TABLE[sel];
        num   <= '0;
        den   <= DEN_W'(1);
      end
      OP_MUL_LO: begin
        acc <= ACC_W'(prod);
      end
      OP_MUL_HI: begin
        acc <= acc + ACC_W'({prod, 16'b0});
      end
      OP_MUL_QB: begin
        qb   <= qb_full[N_W-1:0];
        numb <= numb_full[DEN_W-1:0];
        denb <= denb_full[DEN_W-1:0];
      end
      OP_FIX: begin
        // Append the digit below the reversed digits taken so far.
        n   <= {1'b0, q_fix};
        num <= numb + DEN_W'(digit);
        den <= denb;
      end
      OP_DIV: begin
        num <= div_ge ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
        quo <= {quo[QUO_W-2:0], div_ge};
      end
      OP_SAVE_X: begin
        x_hold <= quo;
      end
      OP_LOAD_OUT: begin
        x_fraction <= x_hold;
        y_fraction <= quo;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/halton_radical_inverse.sv]
`timescale 1ns / 1ps
`default_nettype none
// An item is accepted only in S_IDLE and runs through S_OUT before the next is taken.
// The digit counts kx and ky of (sample_index + 1) in the two bases are at most 33 each.
// Each digit steps through S_MUL_LO, S_MUL_HI, S_MUL_QB and S_FIX on the shared
// reciprocal multiplier, and each axis then runs a 32-bit restoring divider.
// A new item is taken while the previous result waits in the output register.
// Reset (rst, synchronous) clears the controller and out_valid only.
// ----------------------------------------------------------------------------
// halton_radical_inverse
// Two-coordinate Halton point generator: mirrors the digits of the sequence
// index in two prime bases chosen by the dimension number.
// ----------------------------------------------------------------------------
module halton_radical_inverse (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [hri_pkg::IDX_W-1:0]   sample_index,
  input  wire logic [hri_pkg::DIM_W-1:0]   dimension,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [hri_pkg::FRAC_W-1:0]  x_fraction,
  output logic      [hri_pkg::FRAC_W-1:0]  y_fraction
);
  import hri_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  hri_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and result registers.
  hri_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .sample_index (sample_index),
    .dimension    (dimension),
    .x_fraction   (x_fraction),
    .y_fraction   (y_fraction)
  );

endmodule
`default_nettype wire
